FILE: rtl/mbf_pkg.sv
// Shared types and constants of the monochrome bitmap to framebuffer expander.
package mbf_pkg;

   // Saturation limits for the icon size and the line stride
   localparam int MAX_ICON_DIM = 256;
   localparam int MAX_STRIDE   = 4096;

   // Pixel offset width: (4095 + 256) rows * 4096 pixels + 4095 stays below 2^26
   localparam int OFS_W = 26;

   // Configuration register indexes
   localparam logic [2:0] CSR_FRAME_BASE   = 3'd0;
   localparam logic [2:0] CSR_BUFFER_WIDTH = 3'd1;
   localparam logic [2:0] CSR_PIXEL_16BIT  = 3'd2;
   localparam logic [2:0] CSR_START_X      = 3'd3;
   localparam logic [2:0] CSR_START_Y      = 3'd4;
   localparam logic [2:0] CSR_ICON_WIDTH   = 3'd5;
   localparam logic [2:0] CSR_ICON_HEIGHT  = 3'd6;
   localparam logic [2:0] CSR_COLOR_PAIR   = 3'd7;

   // Effective configuration, limits already applied
   typedef struct packed {
      logic [31:0] frame_base;
      logic [12:0] stride;
      logic        pixel_16bit;
      logic [11:0] start_x;
      logic [11:0] start_y;
      logic [8:0]  width;
      logic [8:0]  height;
      logic [31:0] fg;
      logic [31:0] bg;
   } cfg_type;

endpackage

FILE: rtl/mbf_csr.sv
// Configuration registers of the expander, with size limits applied.
module mbf_csr (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_write_data,
   output mbf_pkg::cfg_type   cfg
);

   logic [31:0] frame_base_ff;
   logic [12:0] buffer_width_ff;
   logic        pixel_16bit_ff;
   logic [11:0] start_x_ff;
   logic [11:0] start_y_ff;
   logic [8:0]  icon_width_ff;
   logic [8:0]  icon_height_ff;
   logic [63:0] color_pair_ff;

   logic [8:0]  height_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_base_ff   <= 32'd0;
         buffer_width_ff <= 13'd512;
         pixel_16bit_ff  <= 1'b0;
         start_x_ff      <= 12'd0;
         start_y_ff      <= 12'd0;
         icon_width_ff   <= 9'd16;
         icon_height_ff  <= 9'd16;
         color_pair_ff   <= 64'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            mbf_pkg::CSR_FRAME_BASE:   frame_base_ff   <= csr_write_data[31:0];
            mbf_pkg::CSR_BUFFER_WIDTH: buffer_width_ff <= csr_write_data[12:0];
            mbf_pkg::CSR_PIXEL_16BIT:  pixel_16bit_ff  <= csr_write_data[0];
            mbf_pkg::CSR_START_X:      start_x_ff      <= csr_write_data[11:0];
            mbf_pkg::CSR_START_Y:      start_y_ff      <= csr_write_data[11:0];
            mbf_pkg::CSR_ICON_WIDTH:   icon_width_ff   <= csr_write_data[8:0];
            mbf_pkg::CSR_ICON_HEIGHT:  icon_height_ff  <= csr_write_data[8:0];
            mbf_pkg::CSR_COLOR_PAIR:   color_pair_ff   <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign height_sat = (32'(icon_height_ff) > mbf_pkg::MAX_ICON_DIM) ?
                       9'(mbf_pkg::MAX_ICON_DIM) : icon_height_ff;

   always_comb begin
      cfg.frame_base  = frame_base_ff;
      cfg.stride      = (32'(buffer_width_ff) > mbf_pkg::MAX_STRIDE) ?
                        13'(mbf_pkg::MAX_STRIDE) : buffer_width_ff;
      cfg.pixel_16bit = pixel_16bit_ff;
      cfg.start_x     = start_x_ff;
      cfg.start_y     = start_y_ff;
      cfg.width       = (32'(icon_width_ff) > mbf_pkg::MAX_ICON_DIM) ?
                        9'(mbf_pkg::MAX_ICON_DIM) : icon_width_ff;
      // A zero height counts as one row
      cfg.height      = (height_sat == 9'd0) ? 9'd1 : height_sat;
      cfg.fg          = color_pair_ff[63:32];
      cfg.bg          = color_pair_ff[31:0];
   end

endmodule

FILE: rtl/mono_bitmap_to_framebuffer.sv
// Top level of the monochrome bitmap to framebuffer expander.
// Each accepted byte expands into up to eight pixel writes, issued at one write per cycle
// while the write side is not stalled, from the byte register through the result register.
// A restart byte first sets up the row start offset through the single start_y/stride
// multiplier before its pixels are walked. The same multiplier sets up each following row
// in the cycle of the byte that ends the previous row. The next byte is taken in the cycle
// the current one issues its final write, so bytes follow each other without a gap while
// the write side keeps up.
module mono_bitmap_to_framebuffer (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_bitmap_byte,
   input  logic        req_restart,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_write_address,
   output logic [31:0] rsp_write_data,
   output logic        rsp_last_of_byte,
   output logic        rsp_icon_done
);

   localparam int OW = mbf_pkg::OFS_W;

   mbf_pkg::cfg_type cfg;

   mbf_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // Byte register and walk state
   logic          byte_valid_ff, byte_valid_in;
   logic [7:0]    byte_bits_ff, byte_bits_in;
   logic          restart_ff, restart_in;
   logic [2:0]    pix_ff, pix_in;
   logic [8:0]    column_ff, column_in;
   logic [8:0]    row_ff, row_in;
   logic [OW-1:0] ofs_ff, ofs_in;
   logic          clipped_ff, clipped_in;
   logic          finished_ff, finished_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_addr_ff, rsp_addr_in;
   logic [31:0]   rsp_data_ff, rsp_data_in;
   logic          rsp_last_ff, rsp_last_in;
   logic          rsp_done_ff, rsp_done_in;

   logic          slot_free;
   logic [8:0]    col0;
   logic [9:0]    col10, width10;
   logic [13:0]   xpos, stride14;
   logic          active, clip_now, emit, more;
   logic          row_end, icon_end;
   logic          init, drop, proc, fire, byte_end;
   logic [12:0]   mul_y;
   logic [OW-1:0] row_ofs;
   logic [31:0]   scaled, pix_data;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // Column of the byte's first pixel: every pixel before the current one was written
   assign col0     = column_ff - {6'd0, pix_ff};
   assign col10    = {1'b0, column_ff};
   assign width10  = {1'b0, cfg.width};
   assign xpos     = {2'd0, cfg.start_x} + {5'd0, column_ff};
   assign stride14 = {1'b0, cfg.stride};

   assign active   = col10 < width10;
   assign clip_now = clipped_ff || (xpos >= stride14);
   assign emit     = active && !clip_now;
   // Clipping only grows with the column, so the next pixel tells if this write is the last
   assign more     = emit && (pix_ff != 3'd7) && ((col10 + 10'd1) < width10) &&
                     ((xpos + 14'd1) < stride14);
   assign row_end  = ({1'b0, col0} + 10'd8) >= width10;
   assign icon_end = ({1'b0, row_ff} + 10'd1) >= {1'b0, cfg.height};

   assign init     = byte_valid_ff && restart_ff;
   assign drop     = byte_valid_ff && !restart_ff && finished_ff;
   assign proc     = byte_valid_ff && !restart_ff && !finished_ff;
   assign fire     = proc && (!emit || slot_free);
   assign byte_end = drop || (fire && !more);
   assign req_ready = !byte_valid_ff || byte_end;

   // Row start offset: (start_y + row) * stride + start_x, shared by restart and row change
   assign mul_y   = restart_ff ? {1'b0, cfg.start_y} :
                    ({1'b0, cfg.start_y} + {4'd0, row_ff} + 13'd1);
   assign row_ofs = OW'({13'd0, mul_y} * {13'd0, cfg.stride}) + OW'(cfg.start_x);

   assign scaled   = cfg.pixel_16bit ? 32'({ofs_ff, 1'b0}) : 32'({ofs_ff, 2'b00});
   assign pix_data = byte_bits_ff[3'd7 - pix_ff] ? cfg.fg : cfg.bg;

   always_comb begin
      byte_valid_in = byte_valid_ff;
      byte_bits_in  = byte_bits_ff;
      restart_in    = restart_ff;
      pix_in        = pix_ff;
      column_in     = column_ff;
      row_in        = row_ff;
      ofs_in        = ofs_ff;
      clipped_in    = clipped_ff;
      finished_in   = finished_ff;

      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_done_in   = rsp_done_ff;

      if (init) begin
         // Restart: begin row 0 of a new icon, then walk the byte
         restart_in  = 1'b0;
         finished_in = 1'b0;
         row_in      = 9'd0;
         column_in   = 9'd0;
         clipped_in  = 1'b0;
         ofs_in      = row_ofs;
      end

      if (fire) begin
         if (emit) begin
            rsp_valid_in = 1'b1;
            rsp_addr_in  = cfg.frame_base + scaled;
            rsp_data_in  = cfg.pixel_16bit ? {16'd0, pix_data[15:0]} : pix_data;
            rsp_last_in  = !more;
            rsp_done_in  = !more && row_end && icon_end;
            ofs_in       = ofs_ff + OW'(1);
         end
         if (more) begin
            pix_in    = pix_ff + 3'd1;
            column_in = column_ff + 9'd1;
         end else if (row_end) begin
            row_in     = row_ff + 9'd1;
            column_in  = 9'd0;
            clipped_in = 1'b0;
            if (icon_end) begin
               finished_in = 1'b1;
            end else begin
               ofs_in = row_ofs;
            end
         end else begin
            // All eight pixels fall inside the row: skip past them
            column_in  = col0 + 9'd8;
            clipped_in = clipped_ff ||
                         (({2'd0, cfg.start_x} + {5'd0, col0} + 14'd7) >= stride14);
         end
      end

      if (byte_end) begin
         byte_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         byte_valid_in = 1'b1;
         byte_bits_in  = req_bitmap_byte;
         restart_in    = req_restart;
         pix_in        = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_valid_ff <= 1'b0;
         restart_ff    <= 1'b0;
         pix_ff        <= 3'd0;
         column_ff     <= 9'd0;
         row_ff        <= 9'd0;
         ofs_ff        <= '0;
         clipped_ff    <= 1'b0;
         finished_ff   <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         byte_valid_ff <= byte_valid_in;
         restart_ff    <= restart_in;
         pix_ff        <= pix_in;
         column_ff     <= column_in;
         row_ff        <= row_in;
         ofs_ff        <= ofs_in;
         clipped_ff    <= clipped_in;
         finished_ff   <= finished_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      byte_bits_ff <= byte_bits_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_done_ff  <= rsp_done_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_write_address = rsp_addr_ff;
   assign rsp_write_data    = rsp_data_ff;
   assign rsp_last_of_byte  = rsp_last_ff;
   assign rsp_icon_done     = rsp_done_ff;

endmodule

FILE: rtl/mbf_checker.sv
// Port-level assertions for the expander, bound to the top level.
module mbf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_write_address,
   input logic [31:0] rsp_write_data,
   input logic        rsp_last_of_byte,
   input logic        rsp_icon_done
);

   // Out of reset the block holds no item and takes a byte at once
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   // Icon completion is only flagged on the final write of a byte
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_icon_done) |-> rsp_last_of_byte)
      else $error("icon_done without last_of_byte");

   // Hold a stalled write unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_write_address) &&
                                     $stable(rsp_write_data)))
      else $error("stalled write changed");

endmodule

bind mono_bitmap_to_framebuffer mbf_checker u_mbf_checker (
   .clock             (clock),
   .reset             (reset),
   .req_ready         (req_ready),
   .rsp_valid         (rsp_valid),
   .rsp_ready         (rsp_ready),
   .rsp_write_address (rsp_write_address),
   .rsp_write_data    (rsp_write_data),
   .rsp_last_of_byte  (rsp_last_of_byte),
   .rsp_icon_done     (rsp_icon_done)
);

FILE: verif/mbf_write_checker.sv
// Checker for the bitmap expander: mirrors its registers, predicts every pixel write and compares.
module mbf_write_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_enable,
   input  logic [2:0]  csr_index,
   input  logic [63:0] csr_write_data,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_bitmap_byte,
   input  logic        req_restart,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [31:0] rsp_write_address,
   input  logic [31:0] rsp_write_data,
   input  logic        rsp_last_of_byte,
   input  logic        rsp_icon_done,
   output int          mismatches,
   output int          writes_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [31:0] address;
      logic [31:0] data;
      logic        last_of_byte;
      logic        icon_done;
   } pixel_write_type;

   pixel_write_type queued_pixels[$];

   // register mirror
   logic [31:0] frame_base;
   logic [12:0] buffer_width;
   logic        pixel_16bit;
   logic [11:0] start_x;
   logic [11:0] start_y;
   logic [8:0]  icon_width;
   logic [8:0]  icon_height;
   logic [63:0] color_pair;

   // drawing position
   int unsigned column;
   int unsigned row;
   logic [31:0] pixel_offset;
   logic        row_clipped;
   logic        finished;

   function automatic int unsigned clamp(int unsigned v, int unsigned lim);
      return (v > lim) ? lim : v;
   endfunction

   function automatic logic [31:0] row_start_offset(int unsigned r);
      int unsigned stride;
      stride = clamp(32'(buffer_width), mbf_pkg::MAX_STRIDE);
      return (32'(start_y) + r) * stride + 32'(start_x);
   endfunction

   task automatic apply_register(input logic [2:0] index, input logic [63:0] value);
      case (index)
         mbf_pkg::CSR_FRAME_BASE:   frame_base   = value[31:0];
         mbf_pkg::CSR_BUFFER_WIDTH: buffer_width = value[12:0];
         mbf_pkg::CSR_PIXEL_16BIT:  pixel_16bit  = value[0];
         mbf_pkg::CSR_START_X:      start_x      = value[11:0];
         mbf_pkg::CSR_START_Y:      start_y      = value[11:0];
         mbf_pkg::CSR_ICON_WIDTH:   icon_width   = value[8:0];
         mbf_pkg::CSR_ICON_HEIGHT:  icon_height  = value[8:0];
         mbf_pkg::CSR_COLOR_PAIR:   color_pair   = value;
         default: ;
      endcase
   endtask

   // Expand one accepted byte into the pixel writes it must cause.
   task automatic expand_byte(input logic [7:0] bits, input logic restart);
      pixel_write_type burst[8];
      int unsigned w;
      int unsigned h;
      int unsigned stride;
      int n;
      int p;
      logic [31:0] color;
      logic [31:0] scale;
      w = clamp(32'(icon_width), mbf_pkg::MAX_ICON_DIM);
      h = clamp(32'(icon_height), mbf_pkg::MAX_ICON_DIM);
      if (h == 0) h = 1;
      stride = clamp(32'(buffer_width), mbf_pkg::MAX_STRIDE);
      scale = pixel_16bit ? 32'd2 : 32'd4;
      n = 0;
      if (restart) begin
         finished = 1'b0;
         row = 0;
         column = 0;
         row_clipped = 1'b0;
         pixel_offset = row_start_offset(0);
      end else if (finished) begin
         return;
      end
      for (p = 0; p < 8 && column < w; p++) begin
         if (32'(start_x) + column >= stride) row_clipped = 1'b1;
         if (!row_clipped) begin
            color = bits[7 - p] ? color_pair[63:32] : color_pair[31:0];
            if (pixel_16bit) color[31:16] = '0;
            burst[n] = '{address: frame_base + pixel_offset * scale, data: color,
                         last_of_byte: 1'b0, icon_done: 1'b0};
            n++;
            pixel_offset++;
         end
         column++;
      end
      if (column >= w) begin
         row++;
         column = 0;
         row_clipped = 1'b0;
         if (row >= h) begin
            finished = 1'b1;
            if (n > 0) burst[n - 1].icon_done = 1'b1;
         end else begin
            pixel_offset = row_start_offset(row);
         end
      end
      if (n > 0) burst[n - 1].last_of_byte = 1'b1;
      for (p = 0; p < n; p++) queued_pixels.push_back(burst[p]);
   endtask

   task automatic compare_field(input string field, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
         mismatches++;
      end
   endtask

   task automatic check_write();
      pixel_write_type want;
      if (queued_pixels.size() == 0) begin
         $display("%0t: unexpected write, expected none, actual address %h data %h",
                  $time, rsp_write_address, rsp_write_data);
         mismatches++;
         return;
      end
      want = queued_pixels.pop_front();
      compare_field("write_address", want.address, rsp_write_address);
      compare_field("write_data", want.data, rsp_write_data);
      compare_field("last_of_byte", 32'(want.last_of_byte), 32'(rsp_last_of_byte));
      compare_field("icon_done", 32'(want.icon_done), 32'(rsp_icon_done));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         frame_base   = '0;
         buffer_width = 13'd512;
         pixel_16bit  = 1'b0;
         start_x      = '0;
         start_y      = '0;
         icon_width   = 9'd16;
         icon_height  = 9'd16;
         color_pair   = '0;
         column       = 0;
         row          = 0;
         pixel_offset = '0;
         row_clipped  = 1'b0;
         finished     = 1'b1;
         mismatches   = 0;
         queued_pixels.delete();
      end else begin
         if (csr_write_enable) apply_register(csr_index, csr_write_data);
         if (req_valid && req_ready) expand_byte(req_bitmap_byte, req_restart);
         if (rsp_valid && rsp_ready) check_write();
      end
      writes_pending <= queued_pixels.size();
   end

endmodule

FILE: verif/tb.sv
// Testbench top: clock, reset, register programming, bitmap byte stimulus and verdict.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SETTLE_CYCLES = 16;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int RANDOM_ITEMS  = 480;
   localparam int WHOLE_ICON    = 1 << 20;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_enable = 1'b0;
   logic [2:0]  csr_index = mbf_pkg::CSR_FRAME_BASE;
   logic [63:0] csr_write_data = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_bitmap_byte = '0;
   logic        req_restart = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_write_address;
   logic [31:0] rsp_write_data;
   logic        rsp_last_of_byte;
   logic        rsp_icon_done;

   int mismatches;
   int writes_pending;
   int cycle_count = 0;
   int burst_left = 0;
   int fed_items = 0;
   logic [15:0] ready_pattern = 16'hFFFF;
   logic [5:0]  pattern_age = '0;
   // icon shape as last programmed
   int unsigned cur_width = 16;
   int unsigned cur_height = 16;

   mono_bitmap_to_framebuffer dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_bitmap_byte(req_bitmap_byte),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_write_address(rsp_write_address),
      .rsp_write_data(rsp_write_data),
      .rsp_last_of_byte(rsp_last_of_byte),
      .rsp_icon_done(rsp_icon_done)
   );

   mbf_write_checker write_check (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_bitmap_byte(req_bitmap_byte),
      .req_restart(req_restart),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_write_address(rsp_write_address),
      .rsp_write_data(rsp_write_data),
      .rsp_last_of_byte(rsp_last_of_byte),
      .rsp_icon_done(rsp_icon_done),
      .mismatches(mismatches),
      .writes_pending(writes_pending)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Write side stalls on a rotating pattern; bit 0 of a new pattern is always set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_pattern <= 16'hFFFF;
         pattern_age <= '0;
      end else begin
         rsp_ready <= ready_pattern[0];
         pattern_age <= pattern_age + 6'd1;
         if (pattern_age == '1)
            ready_pattern <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom) | 16'h0001);
         else
            ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
      end
   end

   task automatic put_reg(input logic [2:0] index, input logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index <= index;
      csr_write_data <= value;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [31:0] base, input logic [12:0] stride,
                                input logic half, input logic [11:0] col0,
                                input logic [11:0] row0, input logic [8:0] width,
                                input logic [8:0] height, input logic [63:0] colors);
      put_reg(mbf_pkg::CSR_FRAME_BASE, 64'(base));
      put_reg(mbf_pkg::CSR_BUFFER_WIDTH, 64'(stride));
      put_reg(mbf_pkg::CSR_PIXEL_16BIT, 64'(half));
      put_reg(mbf_pkg::CSR_START_X, 64'(col0));
      put_reg(mbf_pkg::CSR_START_Y, 64'(row0));
      put_reg(mbf_pkg::CSR_ICON_WIDTH, 64'(width));
      put_reg(mbf_pkg::CSR_ICON_HEIGHT, 64'(height));
      put_reg(mbf_pkg::CSR_COLOR_PAIR, colors);
      csr_write_enable <= 1'b0;
      cur_width = 32'(width);
      cur_height = 32'(height);
   endtask

   task automatic load_random_settings(input int unsigned width, input int unsigned height);
      logic [12:0] stride;
      logic [11:0] col0;
      int unsigned eff_stride;
      case ($urandom_range(0, 9))
         0: stride = '0;
         1: stride = 13'($urandom_range(4097, 8191));
         2: stride = 13'd4096;
         default: stride = 13'($urandom_range(1, 4096));
      endcase
      eff_stride = (32'(stride) > mbf_pkg::MAX_STRIDE) ? mbf_pkg::MAX_STRIDE : 32'(stride);
      case ($urandom_range(0, 3))
         0: col0 = 12'($urandom_range(0, 4095));
         // land the clip edge partway along a row
         1: col0 = (eff_stride > 24) ? 12'(eff_stride - $urandom_range(1, 24)) : '0;
         default: col0 = 12'($urandom_range(0, 64));
      endcase
      load_settings($urandom, stride, 1'($urandom_range(0, 1)), col0,
                    12'($urandom_range(0, 4095)), 9'(width), 9'(height),
                    {$urandom, $urandom});
   endtask

   function automatic logic [7:0] pick_bits();
      case ($urandom_range(0, 7))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   task automatic send_byte(input logic [7:0] bits, input logic restart);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
         burst_left = $urandom_range(1, 16);
         if (gap > 0) begin
            if (req_valid) req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_bitmap_byte <= bits;
      req_restart <= restart;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold the sender until every predicted write is out, then let the block go quiet.
   task automatic drain();
      if (req_valid) req_valid <= 1'b0;
      @(posedge clock);
      while (writes_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      burst_left = 0;
   endtask

   // Send one icon as a well-formed byte sequence, cut short at byte_limit.
   task automatic send_icon(input int unsigned byte_limit, input bit reconfig);
      int unsigned w;
      int unsigned h;
      int unsigned per_row;
      int unsigned total;
      int unsigned i;
      w = (cur_width > mbf_pkg::MAX_ICON_DIM) ? mbf_pkg::MAX_ICON_DIM : cur_width;
      h = (cur_height > mbf_pkg::MAX_ICON_DIM) ? mbf_pkg::MAX_ICON_DIM : cur_height;
      if (h == 0) h = 1;
      per_row = (w == 0) ? 1 : (w + 7) / 8;
      total = per_row * h;
      if (byte_limit < total) total = byte_limit;
      for (i = 0; i < total; i++) begin
         if (reconfig && i != 0 && i == total / 2) begin
            drain();
            load_random_settings(cur_width, cur_height);
         end
         send_byte(pick_bits(), i == 0);
         fed_items++;
      end
   endtask

   initial begin
      int unsigned w;
      int unsigned h;
      int phase;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: a byte before any restart is dropped, then a full byte
      send_byte(8'hA5, 1'b0);
      send_byte(8'hFF, 1'b1);
      drain();

      // corner placement with address wrap; row clips after one pixel and the
      // completing byte draws nothing
      load_settings(32'hFFFF_FFF0, 13'd4096, 1'b0, 12'd4095, 12'd4095, 9'd12, 9'd1,
                    64'hFFFF_FFFF_0000_0000);
      send_byte(8'h80, 1'b1);
      send_byte(8'h0F, 1'b0);
      drain();

      // zero width, oversized stride; a byte after the icon is dropped
      load_settings(32'h0000_0100, 13'd8191, 1'b1, 12'd0, 12'd0, 9'd0, 9'd2,
                    64'h1234_5678_9ABC_DEF0);
      send_byte(8'h55, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hC3, 1'b0);
      drain();

      // zero stride clips everything; zero height acts as one row
      load_settings(32'h0000_0200, 13'd0, 1'b0, 12'd0, 12'd0, 9'd8, 9'd0,
                    64'hAAAA_5555_0F0F_F0F0);
      send_byte(8'hFF, 1'b1);
      drain();

      // restart aborts an icon in progress
      load_settings(32'h0000_1000, 13'd4096, 1'b0, 12'd0, 12'd7, 9'd9, 9'd2,
                    64'hDEAD_BEEF_CAFE_F00D);
      send_byte(8'h3C, 1'b1);
      send_byte(8'hC3, 1'b0);
      send_byte(8'h81, 1'b1);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7E, 1'b0);
      send_byte(8'h00, 1'b0);
      drain();

      // registers change mid-icon: colors and clip at once, offset at the next row
      load_settings(32'h0004_0000, 13'd640, 1'b1, 12'd10, 12'd20, 9'd16, 9'd2,
                    64'h0000_F800_0000_07E0);
      send_byte(8'h12, 1'b1);
      drain();
      load_settings(32'h0008_0000, 13'd640, 1'b0, 12'd630, 12'd3, 9'd16, 9'd2,
                    64'h89AB_CDEF_7654_3210);
      send_byte(8'h34, 1'b0);
      send_byte(8'h56, 1'b0);
      send_byte(8'h78, 1'b0);
      drain();

      fed_items = 0;
      phase = 0;
      while (fed_items < RANDOM_ITEMS) begin
         if (phase == 2) begin
            // the one tall icon: height saturates at the limit
            w = $urandom_range(1, 8);
            h = $urandom_range(257, 511);
         end else begin
            case ($urandom_range(0, 15))
               0: w = 0;
               1: w = mbf_pkg::MAX_ICON_DIM;
               2: w = $urandom_range(257, 511);
               3: w = $urandom_range(41, 255);
               default: w = $urandom_range(1, 40);
            endcase
            if (w > 40) h = $urandom_range(0, 2);
            else h = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
         end
         drain();
         load_random_settings(w, h);
         // send the tall icon only once so the item count stays near the target
         repeat ((phase == 2) ? 1 : $urandom_range(1, 3)) begin
            case ($urandom_range(0, 9))
               // cut short: the next restart aborts it
               0: send_icon($urandom_range(1, 6), 1'b0);
               1: send_icon(WHOLE_ICON, 1'b1);
               default: send_icon(WHOLE_ICON, 1'b0);
            endcase
            if ($urandom_range(0, 3) == 0) send_byte(pick_bits(), 1'b0);
         end
         phase++;
      end

      drain();
      if (mismatches == 0 && writes_pending == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
